[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[design/lfgq_pkg.sv]
// ---------------------------------------------------------------------------
// lfgq_pkg
// Field widths, operation codes and controller states for the gap query.
// ---------------------------------------------------------------------------
package lfgq_pkg;

  localparam int POS_W  = 10;
  localparam int SIZE_W = 10;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [14:0] {
    S_CLR   = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_PREV  = 15'b000000000000100,
    S_PREVW = 15'b000000000001000,
    S_LEAF  = 15'b000000000010000,
    S_UPR   = 15'b000000000100000,
    S_UPW   = 15'b000000001000000,
    S_NEXT  = 15'b000000010000000,
    S_NEXTW = 15'b000000100000000,
    S_RL    = 15'b000001000000000,
    S_RLW   = 15'b000010000000000,
    S_RR    = 15'b000100000000000,
    S_RRW   = 15'b001000000000000,
    S_RSH   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

endpackage

[design/lfgq_req_if.sv]
// ---------------------------------------------------------------------------
// lfgq_req_if
// Request channel: operation, position and block size with valid/ready.
// ---------------------------------------------------------------------------
interface lfgq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [lfgq_pkg::POS_W-1:0]  position;
  logic [lfgq_pkg::SIZE_W-1:0] block_size;

  modport source (output valid, operation, position, block_size, input ready);
  modport sink   (input valid, operation, position, block_size, output ready);
endinterface

[design/lfgq_rsp_if.sv]
// ---------------------------------------------------------------------------
// lfgq_rsp_if
// Response channel: fit flag with valid/ready.
// ---------------------------------------------------------------------------
interface lfgq_rsp_if;
  logic valid;
  logic ready;
  logic fits;

  modport source (output valid, fits, input ready);
  modport sink   (input valid, fits, output ready);
endinterface

[design/largest_free_gap_query.sv]
// ---------------------------------------------------------------------------
// largest_free_gap_query
// Obstacle placement and largest-free-gap queries over a max tree in RAM.
// ---------------------------------------------------------------------------
//  channel | dir | payload                          | transaction
//  req     | in  | operation, position, block_size  | valid & ready
//  rsp     | out | fits (queries only)              | valid & ready
//
//  Placement: scans back for the previous obstacle in the obstacle map, writes the new gap
//  into a tree leaf and updates the path to the root, then scans forward; the second tree pass
//  runs only when a later obstacle exists, and placing on an obstacle writes nothing.
//  Query: scans back for the previous obstacle, then walks the tree range up to the position.
//  After reset a clearing pass runs before req.ready rises.
//  rsp sits in an output register; a stalled rsp holds only the final hand-over.
// ---------------------------------------------------------------------------
module largest_free_gap_query #(
  parameter int POSITIONS = 1024
) (
  input logic        clk,
  input logic        rst,
  lfgq_req_if.sink   req,
  lfgq_rsp_if.source rsp
);

  `include "assert_macros.svh"

  localparam int AW  = $clog2(POSITIONS);
  localparam int TW  = $clog2(2 * POSITIONS);
  localparam int RW  = $clog2(2 * POSITIONS + 1);
  localparam int CW  = ((AW > lfgq_pkg::POS_W) ? AW : lfgq_pkg::POS_W) + 1;

  lfgq_pkg::state_t state;

  logic                        op_r;
  logic [AW-1:0]               pos_r;
  logic [lfgq_pkg::SIZE_W-1:0] size_r;
  logic [AW-1:0]               p;
  logic [AW-1:0]               n;
  logic [AW-1:0]               pre;
  logic [AW-1:0]               gv;
  logic [AW-1:0]               best;
  logic [TW-1:0]               idx;
  logic [TW-1:0]               cidx;
  logic [RW-1:0]               l;
  logic [RW-1:0]               r;
  logic                        second;
  logic                        rsp_valid;
  logic                        rsp_fits;

  logic          map_mem [POSITIONS];
  logic [AW-1:0] tree_mem [2*POSITIONS];

  logic [AW-1:0] map_raddr;
  logic          map_q;
  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic          map_wdata;
  logic [TW-1:0] tree_raddr;
  logic [AW-1:0] tree_q;
  logic          tree_we;
  logic [TW-1:0] tree_waddr;
  logic [AW-1:0] tree_wdata;

  logic [CW-1:0] pos_ext;
  logic          in_range;
  logic [AW-1:0] pos_in;
  logic [AW-1:0] up_max;
  logic [TW-1:0] parent;
  logic [AW-1:0] tail_gap;
  logic [AW-1:0] final_best;
  logic          found;

  assign pos_ext    = CW'(req.position);
  assign in_range   = pos_ext < CW'(POSITIONS);
  assign pos_in     = in_range ? AW'(pos_ext) : AW'(POSITIONS - 1);
  assign up_max     = (gv > tree_q) ? gv : tree_q;
  assign parent     = idx >> 1;
  assign tail_gap   = pos_r - pre;
  assign final_best = (tail_gap > best) ? tail_gap : best;
  assign found      = map_q || (p == '0);

  assign req.ready = (state == lfgq_pkg::S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.fits  = rsp_fits;

  // memory port control
  always_comb begin
    map_raddr  = p;
    map_we     = 1'b0;
    map_waddr  = pos_r;
    map_wdata  = 1'b1;
    tree_raddr = idx ^ TW'(1);
    tree_we    = 1'b0;
    tree_waddr = idx;
    tree_wdata = gv;
    unique case (state)
      lfgq_pkg::S_CLR: begin
        map_we     = cidx < TW'(POSITIONS);
        map_waddr  = cidx[AW-1:0];
        map_wdata  = (cidx == '0);
        tree_we    = 1'b1;
        tree_waddr = cidx;
        tree_wdata = '0;
      end
      lfgq_pkg::S_PREVW: begin
        map_we = found && (op_r == lfgq_pkg::OP_PLACE) && (p != pos_r);
      end
      lfgq_pkg::S_LEAF: begin
        tree_we = 1'b1;
      end
      lfgq_pkg::S_UPW: begin
        tree_we    = 1'b1;
        tree_waddr = parent;
        tree_wdata = up_max;
      end
      lfgq_pkg::S_NEXT: begin
        map_raddr = n;
      end
      lfgq_pkg::S_RL: begin
        tree_raddr = l[TW-1:0];
      end
      lfgq_pkg::S_RR: begin
        tree_raddr = r[TW-1:0] - TW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    map_q <= map_mem[map_raddr];
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    tree_q <= tree_mem[tree_raddr];
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lfgq_pkg::S_CLR;
      cidx      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp.ready && (state != lfgq_pkg::S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        lfgq_pkg::S_CLR: begin
          cidx <= cidx + TW'(1);
          if (cidx == TW'(2 * POSITIONS - 1)) begin
            state <= lfgq_pkg::S_IDLE;
          end
        end
        lfgq_pkg::S_IDLE: begin
          if (req.valid) begin
            op_r   <= req.operation;
            pos_r  <= pos_in;
            p      <= pos_in;
            size_r <= req.block_size;
            if (req.operation == lfgq_pkg::OP_QUERY || in_range) begin
              state <= lfgq_pkg::S_PREV;
            end
          end
        end
        lfgq_pkg::S_PREV: begin
          state <= lfgq_pkg::S_PREVW;
        end
        lfgq_pkg::S_PREVW: begin
          if (found) begin
            if (op_r == lfgq_pkg::OP_PLACE) begin
              if (p == pos_r) begin
                state <= lfgq_pkg::S_IDLE;
              end else begin
                gv     <= pos_r - p;
                idx    <= TW'(pos_r) + TW'(POSITIONS);
                second <= 1'b0;
                state  <= lfgq_pkg::S_LEAF;
              end
            end else begin
              pre   <= p;
              best  <= '0;
              l     <= RW'(POSITIONS);
              r     <= RW'(pos_r) + RW'(POSITIONS) + RW'(1);
              state <= lfgq_pkg::S_RL;
            end
          end else begin
            p     <= p - AW'(1);
            state <= lfgq_pkg::S_PREV;
          end
        end
        lfgq_pkg::S_LEAF: begin
          state <= lfgq_pkg::S_UPR;
        end
        lfgq_pkg::S_UPR: begin
          state <= lfgq_pkg::S_UPW;
        end
        lfgq_pkg::S_UPW: begin
          gv  <= up_max;
          idx <= parent;
          if (parent == TW'(1)) begin
            if (second || pos_r == AW'(POSITIONS - 1)) begin
              state <= lfgq_pkg::S_IDLE;
            end else begin
              n     <= pos_r + AW'(1);
              state <= lfgq_pkg::S_NEXT;
            end
          end else begin
            state <= lfgq_pkg::S_UPR;
          end
        end
        lfgq_pkg::S_NEXT: begin
          state <= lfgq_pkg::S_NEXTW;
        end
        lfgq_pkg::S_NEXTW: begin
          if (map_q) begin
            gv     <= n - pos_r;
            idx    <= TW'(n) + TW'(POSITIONS);
            second <= 1'b1;
            state  <= lfgq_pkg::S_LEAF;
          end else if (n == AW'(POSITIONS - 1)) begin
            state <= lfgq_pkg::S_IDLE;
          end else begin
            n     <= n + AW'(1);
            state <= lfgq_pkg::S_NEXT;
          end
        end
        lfgq_pkg::S_RL: begin
          if (l < r) begin
            state <= l[0] ? lfgq_pkg::S_RLW : lfgq_pkg::S_RR;
          end else begin
            state <= lfgq_pkg::S_OUT;
          end
        end
        lfgq_pkg::S_RLW: begin
          if (tree_q > best) begin
            best <= tree_q;
          end
          l     <= l + RW'(1);
          state <= lfgq_pkg::S_RR;
        end
        lfgq_pkg::S_RR: begin
          if (r[0]) begin
            r     <= r - RW'(1);
            state <= lfgq_pkg::S_RRW;
          end else begin
            state <= lfgq_pkg::S_RSH;
          end
        end
        lfgq_pkg::S_RRW: begin
          if (tree_q > best) begin
            best <= tree_q;
          end
          state <= lfgq_pkg::S_RSH;
        end
        lfgq_pkg::S_RSH: begin
          l     <= l >> 1;
          r     <= r >> 1;
          state <= lfgq_pkg::S_RL;
        end
        lfgq_pkg::S_OUT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_fits  <= CW'(final_best) >= CW'(size_r);
            state     <= lfgq_pkg::S_IDLE;
          end
        end
        default: begin
          state <= lfgq_pkg::S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_origin_set, (state == lfgq_pkg::S_PREVW) && (p == '0), map_q, "origin clear")
  `ASSERT_IMPL(a_leaf_gap, state == lfgq_pkg::S_LEAF, gv != '0, "zero gap written")
  `ASSERT_IMPL(a_no_root0, tree_we && (state != lfgq_pkg::S_CLR), tree_waddr != '0, "node 0 hit")
  `ASSERT_NEXT(a_rsp_from_out, !rsp_valid && !rst, !rsp_valid || $past(state == lfgq_pkg::S_OUT),
               "stray response")

endmodule

[tb/sv/tb_largest_free_gap_query.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_largest_free_gap_query
// Drives random and directed placements and fit queries into the gap query
// block with random idling on both channels. A scoreboard class keeps its
// own obstacle line, predicts each fit flag and compares it in order.
// ---------------------------------------------------------------------------
class gap_board;
  localparam int LINE = 1024;
  bit   obstacle [LINE];
  bit   fit_queue [$];
  int   failures;

  function new();
    foreach (obstacle[i]) obstacle[i] = 1'b0;
    obstacle[0] = 1'b1;
    failures = 0;
  endfunction

  function void note(logic op, logic [9:0] pos, logic [9:0] size);
    int last;
    int widest;
    if (op == lfgq_pkg::OP_PLACE) begin
      obstacle[pos] = 1'b1;
    end else begin
      last = 0;
      widest = 0;
      for (int p = 1; p <= pos; p++) begin
        if (obstacle[p]) begin
          if (p - last > widest) widest = p - last;
          last = p;
        end
      end
      if (pos - last > widest) widest = pos - last;
      fit_queue = {fit_queue, bit'(widest >= size)};
    end
  endfunction

  function void check(logic fits);
    bit want;
    if (fit_queue.size() == 0) begin
      $error("fits: unexpected transaction, actual %0b", fits);
      failures++;
    end else begin
      want = fit_queue.pop_front();
      if (fits !== want) begin
        $error("fits: expected %0b actual %0b", want, fits);
        failures++;
      end
    end
  endfunction

  function int pending();
    return fit_queue.size();
  endfunction
endclass

module tb_largest_free_gap_query;
  logic clk;
  logic rst;
  int   item_count;
  bit   quiet;
  logic [9:0] last_place;
  gap_board board;

  lfgq_req_if req ();
  lfgq_rsp_if rsp ();

  largest_free_gap_query dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    rsp.ready <= quiet || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) board.check(rsp.fits);
  end

  task automatic send(logic op, logic [9:0] pos, logic [9:0] size);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.position   <= pos;
    req.block_size <= size;
    do @(posedge clk); while (!req.ready);
    board.note(op, pos, size);
    if (op == lfgq_pkg::OP_PLACE) last_place = pos;
    item_count++;
  endtask

  task automatic send_random();
    logic       op;
    logic [9:0] pos;
    logic [9:0] size;
    int         pick;
    op = $urandom_range(0, 1) ? lfgq_pkg::OP_QUERY : lfgq_pkg::OP_PLACE;
    pick = $urandom_range(0, 99);
    if (pick < 70) pos = 10'($urandom_range(1, 1023));
    else if (pick < 85) pos = last_place + 10'($urandom_range(0, 6)) - 10'd3;
    else pos = 10'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 60) size = 10'($urandom_range(1, 40));
    else if (pick < 95) size = 10'($urandom());
    else size = 10'd0;
    send(op, pos, size);
  endtask

  initial begin
    #400_000_000;
    $display("largest_free_gap_query verification failed");
    $finish;
  end

  initial begin
    int waited;
    board          = new();
    item_count     = 0;
    quiet          = 1'b0;
    last_place     = 10'd1;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.operation  = lfgq_pkg::OP_PLACE;
    req.position   = '0;
    req.block_size = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send(lfgq_pkg::OP_QUERY, 10'd0,    10'd0);
    send(lfgq_pkg::OP_QUERY, 10'd0,    10'd1);
    send(lfgq_pkg::OP_QUERY, 10'd1023, 10'd1023);
    send(lfgq_pkg::OP_QUERY, 10'd1023, 10'd0);
    send(lfgq_pkg::OP_PLACE, 10'd0,    10'd1023);
    send(lfgq_pkg::OP_QUERY, 10'd5,    10'd5);
    send(lfgq_pkg::OP_PLACE, 10'd1023, 10'd0);
    send(lfgq_pkg::OP_PLACE, 10'd1,    10'd0);
    send(lfgq_pkg::OP_QUERY, 10'd1023, 10'd1022);
    send(lfgq_pkg::OP_QUERY, 10'd1022, 10'd1022);
    send(lfgq_pkg::OP_QUERY, 10'd1022, 10'd1021);
    send(lfgq_pkg::OP_PLACE, 10'd512,  10'd0);
    send(lfgq_pkg::OP_PLACE, 10'd512,  10'd0);
    send(lfgq_pkg::OP_QUERY, 10'd1023, 10'd511);
    send(lfgq_pkg::OP_QUERY, 10'd1023, 10'd512);
    send(lfgq_pkg::OP_QUERY, 10'd512,  10'd511);
    send(lfgq_pkg::OP_QUERY, 10'd511,  10'd510);
    send(lfgq_pkg::OP_PLACE, 10'd2,    10'd1023);
    send(lfgq_pkg::OP_QUERY, 10'd2,    10'd1);
    send(lfgq_pkg::OP_QUERY, 10'd2,    10'd2);
    send(lfgq_pkg::OP_QUERY, 10'd1,    10'd0);

    for (int n = 0; n < 880; n++) begin
      quiet = (n >= 300 && n < 450);
      if (n == 600) begin
        req.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
      end
      send_random();
    end
    quiet = 1'b0;
    req.valid <= 1'b0;

    waited = 0;
    while (board.pending() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5000) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("largest_free_gap_query verification clean");
    end else begin
      $display("largest_free_gap_query verification failed");
    end
    $finish;
  end
endmodule

[largest_free_gap_query.f]
+incdir+design
design/lfgq_pkg.sv
design/lfgq_req_if.sv
design/lfgq_rsp_if.sv
design/largest_free_gap_query.sv
tb/sv/tb_largest_free_gap_query.sv
